// ===== rtl/brfc_pkg.sv =====
// Package for the bootloader reply frame checker: item and result types,
// frame phase and status codes, and the byte-wise CRC-16/ARC update.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package brfc_pkg;

	// Largest payload length honored; larger register values are clamped.
	localparam int MAX_PAYLOAD = 256;
	localparam int LEN_W = 9;
	// The clamp as seen through the 9-bit length and byte counter.
	localparam logic [LEN_W-1:0] LEN_CAP =
		(MAX_PAYLOAD > 511) ? 9'd511 : LEN_W'(MAX_PAYLOAD);

	localparam logic [7:0]  ACK_OK   = 8'h30;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [3:0] {
		PH_PAYLOAD = 4'b0001,
		PH_CRC_LO  = 4'b0010,
		PH_CRC_HI  = 4'b0100,
		PH_ACK     = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CRC     = 2'd1,
		ST_BAD_ACK = 2'd2,
		ST_TIMEOUT = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       timed_out;
	} item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       data_valid;
		logic       frame_done;
		status_t    frame_status;
	} result_t;

	// One byte through the reflected CRC-16/ARC shift register.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/brfc_frame_ctrl.sv =====
// Frame sequencer of the reply checker: phase, byte count, running CRC and
// the result of one received byte. Depends on brfc_pkg.
`default_nettype none

module brfc_frame_ctrl (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            step,
	input  wire brfc_pkg::item_t                 item,
	input  wire logic [brfc_pkg::LEN_W-1:0]      payload_length,
	output brfc_pkg::result_t                    result
);
	import brfc_pkg::*;

	phase_t           phase_q, phase_d;
	logic [LEN_W-1:0] bytes_seen_q, bytes_seen_d;
	logic [15:0]      running_crc_q, running_crc_d;
	logic [7:0]       crc_low_q, crc_low_d;
	logic             crc_matched_q, crc_matched_d;
	logic [LEN_W-1:0] eff_len;
	logic [LEN_W-1:0] bytes_inc;

	// A length of zero acts as one; values past the cap act as the cap.
	always_comb begin
		if (payload_length == '0) begin
			eff_len = LEN_W'(1);
		end else if (payload_length > LEN_CAP) begin
			eff_len = LEN_CAP;
		end else begin
			eff_len = payload_length;
		end
	end

	assign bytes_inc = bytes_seen_q + LEN_W'(1);

	always_comb begin
		phase_d       = phase_q;
		bytes_seen_d  = bytes_seen_q;
		running_crc_d = running_crc_q;
		crc_low_d     = crc_low_q;
		crc_matched_d = crc_matched_q;
		result        = '{data_byte: 8'h00, data_valid: 1'b0, frame_done: 1'b0,
			frame_status: ST_OK};
		if (item.timed_out) begin
			result.frame_done   = 1'b1;
			result.frame_status = ST_TIMEOUT;
			phase_d       = PH_PAYLOAD;
			bytes_seen_d  = '0;
			running_crc_d = '0;
			crc_low_d     = '0;
			crc_matched_d = 1'b0;
		end else begin
			case (phase_q)
				PH_PAYLOAD: begin
					result.data_byte  = item.rx_byte;
					result.data_valid = 1'b1;
					running_crc_d = crc16_byte(running_crc_q, item.rx_byte);
					bytes_seen_d  = bytes_inc;
					if (bytes_inc >= eff_len) begin
						phase_d = PH_CRC_LO;
					end
				end
				PH_CRC_LO: begin
					crc_low_d = item.rx_byte;
					phase_d   = PH_CRC_HI;
				end
				PH_CRC_HI: begin
					crc_matched_d = ({item.rx_byte, crc_low_q} == running_crc_q);
					phase_d       = PH_ACK;
				end
				default: begin
					result.frame_done = 1'b1;
					if (!crc_matched_q) begin
						result.frame_status = ST_CRC;
					end else if (item.rx_byte != ACK_OK) begin
						result.frame_status = ST_BAD_ACK;
					end else begin
						result.frame_status = ST_OK;
					end
					phase_d       = PH_PAYLOAD;
					bytes_seen_d  = '0;
					running_crc_d = '0;
					crc_low_d     = '0;
					crc_matched_d = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_PAYLOAD;
			bytes_seen_q  <= '0;
			running_crc_q <= '0;
			crc_low_q     <= '0;
			crc_matched_q <= 1'b0;
		end else if (step) begin
			phase_q       <= phase_d;
			bytes_seen_q  <= bytes_seen_d;
			running_crc_q <= running_crc_d;
			crc_low_q     <= crc_low_d;
			crc_matched_q <= crc_matched_d;
		end
	end

`ifndef SYNTHESIS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.frame_done |=> phase_q == PH_PAYLOAD && bytes_seen_q == '0
			&& running_crc_q == '0 && !crc_matched_q)
		else $error("frame end did not clear the frame state");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> bytes_seen_q < LEN_CAP)
		else $error("payload byte count reached the cap inside the payload");
	a_trailer_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		step && !item.timed_out && (phase_q == PH_CRC_LO || phase_q == PH_CRC_HI)
			|=> running_crc_q == $past(running_crc_q))
		else $error("running CRC moved on a trailer byte");
`endif

endmodule

`default_nettype wire

// ===== rtl/bootloader_reply_frame_checker_unit.sv =====
// Top level of the bootloader reply frame checker: request channels, input
// and result registers, and the payload length register on an APB-style port.
// Depends on brfc_pkg and brfc_frame_ctrl.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  rx_byte, timed_out
//   result    out        out_valid/out_stall  data_byte, data_valid, frame_done, frame_status
//   config    in         psel/penable/pready  paddr, pwdata, prdata (payload_length)
//
// Every request yields exactly one result request, held first in the input
// register and then in the result register. A new request is taken in
// every cycle while the result side is not stalled; the rate is set by the
// combinational CRC byte update between the input register and the result register.
// Reset clears the frame state, both valid flags, and sets payload_length to 1.
// A stalled result holds in the result register while one more request waits
// in the input register; only then does in_stall rise.
`default_nettype none

module bootloader_reply_frame_checker_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input request channel.
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        timed_out,
	// Result request channel.
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       data_byte,
	output logic             data_valid,
	output logic             frame_done,
	output logic [1:0]       frame_status,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import brfc_pkg::*;

	logic             valid_s1;
	item_t            item_s1;
	logic             out_valid_q;
	result_t          result_q;
	result_t          result_d;
	logic             out_free;
	logic             advance;
	logic             in_take;
	logic [LEN_W-1:0] payload_length_q;

	// The only register sits at address zero, so the decode needs no
	// address bits; reads return it zero-extended.
	assign pready = 1'b1;
	assign prdata = {{(32 - LEN_W){1'b0}}, payload_length_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_length_q <= LEN_W'(1);
		end else if (psel && penable && pwrite && pready && paddr == 2'b00) begin
			payload_length_q <= pwdata[LEN_W-1:0];
		end else if (psel && penable && pwrite && pready) begin
			payload_length_q <= pwdata[LEN_W-1:0];
		end
	end

	// The result register can load when it is empty or being drained; the
	// input register moves its request on whenever the result register loads.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= '{rx_byte: rx_byte, timed_out: timed_out};
		end
	end

	brfc_frame_ctrl u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.item           (item_s1),
		.payload_length (payload_length_q),
		.result         (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign data_byte    = result_q.data_byte;
	assign data_valid   = result_q.data_valid;
	assign frame_done   = result_q.frame_done;
	assign frame_status = result_q.frame_status;

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");
	a_hold_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && out_stall |=> valid_s1 && out_valid_q)
		else $error("a waiting request was dropped");
	a_drain_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !valid_s1 && !out_stall |=> !out_valid_q)
		else $error("a result appeared with no request behind it");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for bootloader_reply_frame_checker_unit. A table of short directed frames
// comes first, then random, mostly well-formed frames checked against a behavioral model.
// Depends on brfc_pkg and on the RTL of the block.

module tb_top;
	import brfc_pkg::*;

	// The run is stopped here if it has not finished by then.
	localparam int CYCLE_LIMIT = 400000;
	// Length of the long receiver hold-off that fills the block up.
	localparam int HOLD_CYCLES = 300;
	// Extra wait after the last result is back, before the final verdict.
	localparam int DRAIN_CYCLES = 8;
	localparam logic [1:0] ADDR_PAYLOAD_LENGTH = 2'd0;
	// Length register settings of the random phases; later phases pick a small random length.
	localparam int unsigned PHASE_LENGTHS [7] = '{3, 1, 256, 0, 17, 511, 2};
	localparam int N_PHASES = 10;

	typedef enum logic {ROW_ITEM, ROW_LENGTH} row_kind_t;

	// One row of the directed table: either a request or a write of the length register.
	// Where typed is set, want holds the expected result; otherwise the model decides.
	typedef struct packed {
		row_kind_t  kind;
		logic [8:0] length;
		logic [7:0] rx;
		logic       tmo;
		logic       typed;
		result_t    want;
	} stim_row_t;

	localparam result_t R_TRAILER  = {8'h00, 1'b0, 1'b0, ST_OK};
	localparam result_t R_DONE_OK  = {8'h00, 1'b0, 1'b1, ST_OK};
	localparam result_t R_DONE_CRC = {8'h00, 1'b0, 1'b1, ST_CRC};
	localparam result_t R_DONE_ACK = {8'h00, 1'b0, 1'b1, ST_BAD_ACK};
	localparam result_t R_TIMEOUT  = {8'h00, 1'b0, 1'b1, ST_TIMEOUT};
	localparam result_t R_NONE     = '0;

	localparam int N_ROWS = 28;
	stim_row_t directed_rows [N_ROWS] = '{
		// Length 1 after reset. Payload 0x00 has CRC 0x0000, so this frame is good.
		{ROW_ITEM,   9'd0, 8'h00, 1'b0, 1'b1, {8'h00, 1'b1, 1'b0, ST_OK}},
		{ROW_ITEM,   9'd0, 8'h00, 1'b0, 1'b1, R_TRAILER},
		{ROW_ITEM,   9'd0, 8'h00, 1'b0, 1'b1, R_TRAILER},
		{ROW_ITEM,   9'd0, 8'h30, 1'b0, 1'b1, R_DONE_OK},
		// Payload 0xFF with a zero CRC and a bad ack: the CRC mismatch wins.
		{ROW_ITEM,   9'd0, 8'hFF, 1'b0, 1'b1, {8'hFF, 1'b1, 1'b0, ST_OK}},
		{ROW_ITEM,   9'd0, 8'h00, 1'b0, 1'b1, R_TRAILER},
		{ROW_ITEM,   9'd0, 8'h00, 1'b0, 1'b1, R_TRAILER},
		{ROW_ITEM,   9'd0, 8'h55, 1'b0, 1'b1, R_DONE_CRC},
		// Timeout at the start of a frame; the byte that comes with it is ignored.
		{ROW_ITEM,   9'd0, 8'hFF, 1'b1, 1'b1, R_TIMEOUT},
		// A length of zero behaves as one. Good CRC, bad ack.
		{ROW_LENGTH, 9'd0, 8'h00, 1'b0, 1'b0, R_NONE},
		{ROW_ITEM,   9'd0, 8'h00, 1'b0, 1'b1, {8'h00, 1'b1, 1'b0, ST_OK}},
		{ROW_ITEM,   9'd0, 8'h00, 1'b0, 1'b1, R_TRAILER},
		{ROW_ITEM,   9'd0, 8'h00, 1'b0, 1'b1, R_TRAILER},
		{ROW_ITEM,   9'd0, 8'hFF, 1'b0, 1'b1, R_DONE_ACK},
		// Timeouts while waiting for the CRC low byte and the CRC high byte.
		{ROW_ITEM,   9'd0, 8'h5A, 1'b0, 1'b1, {8'h5A, 1'b1, 1'b0, ST_OK}},
		{ROW_ITEM,   9'd0, 8'hAA, 1'b1, 1'b1, R_TIMEOUT},
		{ROW_ITEM,   9'd0, 8'h5A, 1'b0, 1'b1, {8'h5A, 1'b1, 1'b0, ST_OK}},
		{ROW_ITEM,   9'd0, 8'h00, 1'b0, 1'b1, R_TRAILER},
		{ROW_ITEM,   9'd0, 8'h00, 1'b1, 1'b1, R_TIMEOUT},
		// Three payload bytes of four, then the length drops to two mid-frame:
		// the next payload byte is the last one.
		{ROW_LENGTH, 9'd4, 8'h00, 1'b0, 1'b0, R_NONE},
		{ROW_ITEM,   9'd0, 8'h01, 1'b0, 1'b1, {8'h01, 1'b1, 1'b0, ST_OK}},
		{ROW_ITEM,   9'd0, 8'h80, 1'b0, 1'b1, {8'h80, 1'b1, 1'b0, ST_OK}},
		{ROW_ITEM,   9'd0, 8'h7F, 1'b0, 1'b1, {8'h7F, 1'b1, 1'b0, ST_OK}},
		{ROW_LENGTH, 9'd2, 8'h00, 1'b0, 1'b0, R_NONE},
		{ROW_ITEM,   9'd0, 8'hC3, 1'b0, 1'b0, R_NONE},
		{ROW_ITEM,   9'd0, 8'h12, 1'b0, 1'b0, R_NONE},
		{ROW_ITEM,   9'd0, 8'h34, 1'b0, 1'b0, R_NONE},
		// Timeout in place of the ack byte.
		{ROW_ITEM,   9'd0, 8'h30, 1'b1, 1'b1, R_TIMEOUT}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        timed_out = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  data_byte;
	logic        data_valid;
	logic        frame_done;
	logic [1:0]  frame_status;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = 2'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// Model of the frame checker: its own copy of the length register and frame state.
	logic [8:0]  length_reg;
	phase_t      frame_phase;
	logic [8:0]  bytes_seen;
	logic [15:0] crc_acc;
	logic [7:0]  crc_low_rx;
	logic        crc_good;

	// Results still owed by the block, oldest first.
	result_t expected_replies[$];

	int  mismatches = 0;
	int  cycles = 0;
	// Set while neither side may idle.
	bit  quiet = 1'b0;
	// The stimulus asks for a long receiver hold-off by bumping holds_asked.
	int  holds_asked = 0;
	int  holds_done = 0;
	int  hold_left = 0;

	bootloader_reply_frame_checker_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.timed_out    (timed_out),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_byte    (data_byte),
		.data_valid   (data_valid),
		.frame_done   (frame_done),
		.frame_status (frame_status),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Reflected CRC-16/ARC, one input bit at a time, LSB first.
	function automatic logic [15:0] arc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        feedback;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			feedback = c[0] ^ b[i];
			c = {1'b0, c[15:1]};
			if (feedback) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// Payload length actually used for a given register value.
	function automatic int unsigned frame_length(input logic [8:0] reg_value);
		if (reg_value == 9'd0) begin
			return 1;
		end
		if (reg_value > MAX_PAYLOAD) begin
			return MAX_PAYLOAD;
		end
		return reg_value;
	endfunction

	function automatic void clear_frame_state();
		frame_phase = PH_PAYLOAD;
		bytes_seen  = 9'd0;
		crc_acc     = 16'h0000;
		crc_low_rx  = 8'h00;
		crc_good    = 1'b0;
	endfunction

	// Advances the model by one received byte and returns the result it owes.
	function automatic result_t predict_reply(input logic [7:0] b, input logic tmo);
		result_t r;
		r = '0;
		if (tmo) begin
			r.frame_done   = 1'b1;
			r.frame_status = ST_TIMEOUT;
			clear_frame_state();
			return r;
		end
		case (frame_phase)
			PH_PAYLOAD: begin
				r.data_byte  = b;
				r.data_valid = 1'b1;
				crc_acc      = arc_fold(crc_acc, b);
				bytes_seen   = bytes_seen + 9'd1;
				// Compared against the current length, so a length lowered
				// mid-frame ends the payload on the next byte.
				if (bytes_seen >= frame_length(length_reg)) begin
					frame_phase = PH_CRC_LO;
				end
			end
			PH_CRC_LO: begin
				crc_low_rx  = b;
				frame_phase = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				crc_good    = ({b, crc_low_rx} == crc_acc);
				frame_phase = PH_ACK;
			end
			default: begin
				// A CRC mismatch is reported even when the ack is bad as well.
				r.frame_done = 1'b1;
				if (!crc_good) begin
					r.frame_status = ST_CRC;
				end else if (b != ACK_OK) begin
					r.frame_status = ST_BAD_ACK;
				end else begin
					r.frame_status = ST_OK;
				end
				clear_frame_state();
			end
		endcase
		return r;
	endfunction

	// Offers one request, possibly after a short gap, and records what it should produce.
	// A typed expectation replaces the model's answer, but the model still advances.
	task automatic send_request(input logic [7:0] b, input logic tmo, input logic typed,
			input result_t want);
		result_t predicted;
		if (!quiet && $urandom_range(99) < 13) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		rx_byte   <= b;
		timed_out <= tmo;
		do @(posedge clk); while (in_stall);
		predicted = predict_reply(b, tmo);
		expected_replies.push_back(typed ? want : predicted);
	endtask

	// Stops offering requests and waits until every owed result has come back.
	task automatic wait_for_replies();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
	endtask

	// Writes the payload length register once the block is idle: setup, then access.
	task automatic write_length(input logic [8:0] value);
		wait_for_replies();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_PAYLOAD_LENGTH;
		pwdata  <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		length_reg = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Receiver pacing. A requested hold-off keeps out_stall high until the count kept here
	// runs out; otherwise the receiver stalls with a probability of about 13 percent,
	// except during the quiet stretch.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (holds_done != holds_asked) begin
			holds_done++;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < 13);
		end
	end

	// Every accepted result is compared field by field with the oldest expectation.
	always @(posedge clk) begin : check_replies
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_replies.size() == 0) begin
				$error("result with no request outstanding: data_byte %h frame_done %b",
					data_byte, frame_done);
				mismatches++;
			end else begin
				want = expected_replies.pop_front();
				if (data_byte !== want.data_byte) begin
					$error("data_byte: expected %h, got %h", want.data_byte, data_byte);
					mismatches++;
				end
				if (data_valid !== want.data_valid) begin
					$error("data_valid: expected %b, got %b", want.data_valid, data_valid);
					mismatches++;
				end
				if (frame_done !== want.frame_done) begin
					$error("frame_done: expected %b, got %b", want.frame_done, frame_done);
					mismatches++;
				end
				if (frame_status !== want.frame_status) begin
					$error("frame_status: expected %0d, got %0d", want.frame_status,
						frame_status);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned len_setting;
		int unsigned budget;
		logic [7:0]  b;
		logic [7:0]  flip;
		logic        tmo;
		length_reg = 9'd1;
		clear_frame_state();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed frames.
		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_LENGTH) begin
				write_length(directed_rows[r].length);
			end else begin
				send_request(directed_rows[r].rx, directed_rows[r].tmo,
					directed_rows[r].typed, directed_rows[r].want);
			end
		end

		// Random phases, one length setting each. The register is written between
		// phases, so a phase may start in the middle of a frame left by the one before.
		for (int p = 0; p < N_PHASES; p++) begin
			len_setting = (p < 7) ? PHASE_LENGTHS[p] : $urandom_range(1, 24);
			write_length(9'(len_setting));
			// The second phase runs with neither side idling.
			quiet = (p == 1);
			budget = (frame_length(length_reg) > 32) ? 270 : 180;
			for (int i = 0; i < budget; i++) begin
				// Long receiver hold-offs while requests keep coming, so the block
				// fills up and stalls its input.
				if ((p == 0 && i == 60) || (p == 2 && i == 100)) begin
					holds_asked++;
				end
				// Once, the sender pauses mid-phase until every result is back.
				if (p == 4 && i == 90) begin
					wait_for_replies();
				end
				// Mostly well-formed frames: the trailer carries the right CRC
				// unless corrupted, and the ack is usually good. Timeouts are rare
				// on long frames so that those frames get through.
				b = 8'($urandom_range(255));
				flip = ($urandom_range(99) < 12) ? 8'($urandom_range(1, 255)) : 8'h00;
				tmo = ($urandom_range(999) < ((frame_length(length_reg) > 32) ? 1 : 20));
				if (!tmo) begin
					case (frame_phase)
						PH_CRC_LO: b = crc_acc[7:0] ^ flip;
						PH_CRC_HI: b = crc_acc[15:8] ^ flip;
						PH_ACK: begin
							if ($urandom_range(99) < 85) begin
								b = ACK_OK;
							end
						end
						default: ;
					endcase
				end
				send_request(b, tmo, 1'b0, R_NONE);
			end
		end
		quiet = 1'b0;

		wait_for_replies();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_replies.size() != 0) begin
			$error("%0d results never arrived", expected_replies.size());
		end
		if (mismatches == 0 && expected_replies.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
